// ----- rtl/core/rmdr_pkg.sv -----
// Shared types and constants of the rational multiply, divide and reduce block.
package rmdr_pkg;

  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DEN_W      = 31;
  localparam int unsigned MAG_W      = 63;
  localparam int unsigned CNT_W      = 6;

  localparam logic [MAG_W-1:0] RES_LIMIT = MAG_W'((64'd1 << (WORD_WIDTH - 1)) - 64'd1);

  localparam logic [1:0] KIND_NORM = 2'd0;
  localparam logic [1:0] KIND_MUL  = 2'd1;
  localparam logic [1:0] KIND_DIV  = 2'd2;
  localparam logic [1:0] KIND_CMP  = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZDEN = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  typedef enum logic {
    MODE_GCD,
    MODE_DIV
  } rmdr_mode_e;

  typedef struct packed {
    logic       start;
    rmdr_mode_e mode;
  } rmdr_cmd_t;

  function automatic logic [DATA_W-1:0] mag32(logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

endpackage

// ----- rtl/core/rmdr_iter.sv -----
// Shared subtract-and-shift unit: binary GCD and restoring division, one step a cycle.
module rmdr_iter import rmdr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rmdr_cmd_t        cmd_i,
  input  logic [MAG_W-1:0] opa_i,
  input  logic [MAG_W-1:0] opb_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [MAG_W-1:0] res_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  rmdr_mode_e       mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] x_q, x_d;
  logic [MAG_W-1:0] y_q, y_d;
  logic [MAG_W-1:0] z_q, z_d;

  logic [MAG_W:0]   sub_a;
  logic [MAG_W+1:0] diff;
  logic             borrow;

  // one subtractor serves both modes
  assign sub_a  = (mode_q == MODE_DIV) ? {x_q, z_q[MAG_W-1]} : {1'b0, x_q};
  assign diff   = {1'b0, sub_a} - {2'b00, y_q};
  assign borrow = diff[MAG_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (cmd_i.start && !busy_q) begin
      busy_d = 1'b1;
      mode_d = cmd_i.mode;
      y_d    = opb_i;
      if (cmd_i.mode == MODE_GCD) begin
        x_d   = opa_i;
        cnt_d = '0;
      end else begin
        x_d   = '0;
        z_d   = opa_i;
        cnt_d = CNT_W'(MAG_W - 1);
      end
    end else if (busy_q) begin
      if (mode_q == MODE_GCD) begin
        priority if (x_q == '0) begin
          z_d    = y_q << cnt_q;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d   = x_q >> 1;
          y_d   = y_q >> 1;
          cnt_d = cnt_q + CNT_W'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (!borrow) begin
          x_d = diff[MAG_W-1:0];
        end else begin
          x_d = y_q;
          y_d = x_q;
        end
      end else begin
        x_d = borrow ? sub_a[MAG_W-1:0] : diff[MAG_W-1:0];
        z_d = {z_q[MAG_W-2:0], !borrow};
        if (cnt_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= MODE_GCD;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = z_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("iter: done while busy");
  a_gcd_y_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && mode_q == MODE_GCD) |-> (y_q != '0)) else $error("iter: gcd operand zero");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q) else $error("iter: start while busy");
`endif

endmodule

// ----- rtl/core/rational_mul_div_reduce.sv -----
// Top level: rational multiply, divide, normalise and compare with GCD reduction.
//
//  channel  | handshake                 | fields
//  ---------+---------------------------+-----------------------------------------------
//  item in  | start_i, busy_o           | kind_i, lhs_/rhs_ numerator_i, denominator_i
//  item out | done_o (one-cycle strobe) | result_numerator_o, result_denominator_o,
//           |                           | is_equal_o, status_o
//
//  Compare: result in the cycle after acceptance, busy_o stays low.
//  Other kinds: two multiplies and a check (S_MULN, S_MULD, S_CHK), then binary GCD
//  on the shared subtractor, then two 63-step divisions by the GCD, each started
//  when the previous run of the iterative unit reports done.
//  Zero numerator or zero denominator ends after the check.
//  Reset clears the sequencer; the receiver cannot stall, done_o is never held.
module rational_mul_div_reduce import rmdr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              kind_i,
  input  logic signed [DATA_W-1:0] lhs_numerator_i,
  input  logic signed [DATA_W-1:0] lhs_denominator_i,
  input  logic signed [DATA_W-1:0] rhs_numerator_i,
  input  logic signed [DATA_W-1:0] rhs_denominator_i,
  output logic                    done_o,
  output logic signed [DATA_W-1:0] result_numerator_o,
  output logic [DEN_W-1:0]        result_denominator_o,
  output logic                    is_equal_o,
  output logic [1:0]              status_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULN = 3'd1;
  localparam logic [2:0] S_MULD = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DVN  = 3'd5;
  localparam logic [2:0] S_DVD  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [1:0]        kind_q, kind_d;
  logic [DATA_W-1:0] ln_q, ln_d, ld_q, ld_d, rn_q, rn_d, rd_q, rd_d;
  logic [MAG_W-1:0]  nm_q, nm_d, dm_q, dm_d, g_q, g_d;
  logic              done_q, done_d, eq_q, eq_d;
  logic [DATA_W-1:0] num_q, num_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [1:0]        stat_q, stat_d;

  logic [DATA_W-1:0]   mul_a, mul_b;
  logic [2*DATA_W-1:0] prod;
  logic                neg;

  rmdr_cmd_t        it_cmd;
  logic [MAG_W-1:0] it_opa, it_opb, it_res;
  logic             it_busy, it_done;

  rmdr_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (it_cmd),
    .opa_i  (it_opa),
    .opb_i  (it_opb),
    .busy_o (it_busy),
    .done_o (it_done),
    .res_o  (it_res)
  );

  assign neg = ln_q[DATA_W-1] ^ ld_q[DATA_W-1] ^
               ((kind_q != KIND_NORM) & (rn_q[DATA_W-1] ^ rd_q[DATA_W-1]));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_MULN) begin
      mul_a = mag32(ln_q);
      unique case (kind_q)
        KIND_MUL: mul_b = mag32(rn_q);
        KIND_DIV: mul_b = mag32(rd_q);
        default:  mul_b = DATA_W'(1);
      endcase
    end else begin
      mul_a = mag32(ld_q);
      unique case (kind_q)
        KIND_MUL: mul_b = mag32(rd_q);
        KIND_DIV: mul_b = mag32(rn_q);
        default:  mul_b = DATA_W'(1);
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    ln_d        = ln_q;
    ld_d        = ld_q;
    rn_d        = rn_q;
    rd_d        = rd_q;
    nm_d        = nm_q;
    dm_d        = dm_q;
    g_d         = g_q;
    done_d      = 1'b0;
    eq_d        = eq_q;
    num_d       = num_q;
    den_d       = den_q;
    stat_d      = stat_q;
    it_cmd      = '{start: 1'b0, mode: MODE_GCD};
    it_opa      = nm_q;
    it_opb      = dm_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d = kind_i;
          ln_d   = lhs_numerator_i;
          ld_d   = lhs_denominator_i;
          rn_d   = rhs_numerator_i;
          rd_d   = rhs_denominator_i;
          if (kind_i == KIND_CMP) begin
            done_d = 1'b1;
            eq_d   = (lhs_numerator_i == rhs_numerator_i) &&
                     (lhs_denominator_i == rhs_denominator_i);
            num_d  = '0;
            den_d  = '0;
            stat_d = STAT_OK;
          end else begin
            state_d = S_MULN;
          end
        end
      end
      S_MULN: begin
        nm_d    = prod[MAG_W-1:0];
        state_d = S_MULD;
      end
      S_MULD: begin
        dm_d    = prod[MAG_W-1:0];
        state_d = S_CHK;
      end
      S_CHK: begin
        eq_d = 1'b0;
        priority if (nm_q == '0) begin
          num_d   = '0;
          den_d   = DEN_W'(1);
          stat_d  = STAT_OK;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (dm_q == '0) begin
          num_d   = '0;
          den_d   = '0;
          stat_d  = STAT_ZDEN;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          it_cmd  = '{start: 1'b1, mode: MODE_GCD};
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (it_done) begin
          g_d     = it_res;
          it_cmd  = '{start: 1'b1, mode: MODE_DIV};
          it_opa  = nm_q;
          it_opb  = it_res;
          state_d = S_DVN;
        end
      end
      S_DVN: begin
        if (it_done) begin
          nm_d    = it_res;
          it_cmd  = '{start: 1'b1, mode: MODE_DIV};
          it_opa  = dm_q;
          it_opb  = g_q;
          state_d = S_DVD;
        end
      end
      S_DVD: begin
        if (it_done) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if ((it_res > RES_LIMIT) || (nm_q > (RES_LIMIT + MAG_W'(neg)))) begin
            num_d  = '0;
            den_d  = '0;
            stat_d = STAT_OVF;
          end else begin
            num_d  = neg ? (~nm_q[DATA_W-1:0] + DATA_W'(1)) : nm_q[DATA_W-1:0];
            den_d  = it_res[DEN_W-1:0];
            stat_d = STAT_OK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    ln_q   <= ln_d;
    ld_q   <= ld_d;
    rn_q   <= rn_d;
    rd_q   <= rd_d;
    nm_q   <= nm_d;
    dm_q   <= dm_d;
    g_q    <= g_d;
    eq_q   <= eq_d;
    num_q  <= num_d;
    den_q  <= den_d;
    stat_q <= stat_d;
  end

  assign busy_o               = (state_q != S_IDLE);
  assign done_o               = done_q;
  assign result_numerator_o   = num_q;
  assign result_denominator_o = den_q;
  assign is_equal_o           = eq_q;
  assign status_o             = stat_q;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |-> (result_numerator_o == '0 &&
    result_denominator_o == '0)) else $error("top: error result not zeroed");
  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_equal_o) |-> (result_denominator_o == '0 && status_o == STAT_OK))
    else $error("top: equal flag on reduced result");
  a_accept_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o)) else $error("top: item dropped");
  a_iter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !it_busy) else $error("top: unit busy while idle");
`endif

endmodule

// ----- tb/rational_mul_div_reduce_test.sv -----
// Self-checking testbench for the rational multiply, divide, normalise and compare block.
module rational_mul_div_reduce_test;
  import rmdr_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 400;
  localparam int TIMEOUT_CYCLES = 4_000_000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] num;
    logic [DEN_W-1:0]         den;
    logic                     eq;
    logic [1:0]               status;
  } ratio_res_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic [1:0]               kind_i = KIND_NORM;
  logic signed [DATA_W-1:0] lhs_numerator_i = '0;
  logic signed [DATA_W-1:0] lhs_denominator_i = '0;
  logic signed [DATA_W-1:0] rhs_numerator_i = '0;
  logic signed [DATA_W-1:0] rhs_denominator_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic signed [DATA_W-1:0] result_numerator_o;
  logic [DEN_W-1:0]         result_denominator_o;
  logic                     is_equal_o;
  logic [1:0]               status_o;

  ratio_res_t pending_ratios[$];
  int unsigned mismatch_count = 0;

  rational_mul_div_reduce uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .kind_i               (kind_i),
    .lhs_numerator_i      (lhs_numerator_i),
    .lhs_denominator_i    (lhs_denominator_i),
    .rhs_numerator_i      (rhs_numerator_i),
    .rhs_denominator_i    (rhs_denominator_i),
    .done_o               (done_o),
    .result_numerator_o   (result_numerator_o),
    .result_denominator_o (result_denominator_o),
    .is_equal_o           (is_equal_o),
    .status_o             (status_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic ratio_res_t reduce_ratio(input logic [1:0] kind,
                                               input logic signed [DATA_W-1:0] ln,
                                               input logic signed [DATA_W-1:0] ld,
                                               input logic signed [DATA_W-1:0] rn,
                                               input logic signed [DATA_W-1:0] rd);
    longint n;
    longint d;
    longint unsigned nm;
    longint unsigned dm;
    longint unsigned a;
    longint unsigned b;
    longint unsigned lim;
    longint unsigned signed_num;
    logic neg;
    ratio_res_t r;
    r = '0;
    if (kind == KIND_CMP) begin
      r.eq = (ln == rn) && (ld == rd);
      return r;
    end
    case (kind)
      KIND_NORM: begin
        n = longint'(ln);
        d = longint'(ld);
      end
      KIND_MUL: begin
        n = longint'(ln) * longint'(rn);
        d = longint'(ld) * longint'(rd);
      end
      default: begin
        n = longint'(ln) * longint'(rd);
        d = longint'(ld) * longint'(rn);
      end
    endcase
    if (n == 0) begin
      r.den = DEN_W'(1);
    end else if (d == 0) begin
      r.status = STAT_ZDEN;
    end else begin
      nm = (n < 0) ? longint'(-n) : n;
      dm = (d < 0) ? longint'(-d) : d;
      neg = (n < 0) != (d < 0);
      a = nm;
      b = dm;
      while (a != 0 && b != 0) begin
        if (a > b) a = a % b;
        else b = b % a;
      end
      nm = nm / (a + b);
      dm = dm / (a + b);
      lim = (64'd1 << (WORD_WIDTH - 1)) - 64'd1;
      if (dm > lim || nm > lim + (neg ? 64'd1 : 64'd0)) begin
        r.status = STAT_OVF;
      end else begin
        signed_num = neg ? (64'd0 - nm) : nm;
        r.num = signed_num[DATA_W-1:0];
        r.den = dm[DEN_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    logic signed [DATA_W-1:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2: w = $urandom;
      3: begin
        case ($urandom_range(0, 5))
          0: w = 0;
          1: w = 1;
          2: w = 32'h7fff_ffff;
          3: w = 32'h8000_0000;
          4: w = 32'h8000_0001;
          default: w = 32'h0001_0000;
        endcase
      end
      4, 5, 6: w = $urandom_range(1, 2000) * $urandom_range(1, 2000);
      default: w = $urandom_range(0, 60);
    endcase
    if ($urandom_range(0, 1) == 1) w = -w;
    return w;
  endfunction

  task automatic send_item(input logic [1:0] kind,
                           input logic signed [DATA_W-1:0] ln,
                           input logic signed [DATA_W-1:0] ld,
                           input logic signed [DATA_W-1:0] rn,
                           input logic signed [DATA_W-1:0] rd);
    start_i <= 1'b1;
    kind_i <= kind;
    lhs_numerator_i <= ln;
    lhs_denominator_i <= ld;
    rhs_numerator_i <= rn;
    rhs_denominator_i <= rd;
    do @(posedge clk_i); while (busy_o);
    pending_ratios.push_back(reduce_ratio(kind, ln, ld, rn, rd));
  endtask

  task automatic idle_for(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    ratio_res_t want;
    if (rst_ni && done_o) begin
      if (pending_ratios.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result %0d/%0d eq=%0d status=%0d", result_numerator_o,
                   result_denominator_o, is_equal_o, status_o);
      end else begin
        want = pending_ratios.pop_front();
        if (result_numerator_o !== want.num || result_denominator_o !== want.den ||
            is_equal_o !== want.eq || status_o !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: expected %0d/%0d eq=%0d status=%0d, got %0d/%0d eq=%0d status=%0d",
                     want.num, want.den, want.eq, want.status, result_numerator_o,
                     result_denominator_o, is_equal_o, status_o);
        end
      end
    end
  end

  task automatic test_extremes();
    send_item(KIND_NORM, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send_item(KIND_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_item(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(KIND_CMP, -1, -1, -1, -1);
    send_item(KIND_CMP, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    drain_results();
  endtask

  task automatic test_kinds();
    send_item(KIND_NORM, 6, 4, 0, 0);
    send_item(KIND_NORM, -6, 4, 0, 0);
    send_item(KIND_NORM, 6, -4, 0, 0);
    send_item(KIND_NORM, -6, -4, 0, 0);
    send_item(KIND_MUL, 2, 3, 3, 4);
    send_item(KIND_DIV, 2, 3, -4, 9);
    send_item(KIND_CMP, 1, 2, 1, 2);
    send_item(KIND_CMP, 1, 2, 2, 4);
    drain_results();
  endtask

  task automatic test_special_cases();
    // zero numerator wins over zero denominator; zero denominator alone gives STAT_ZDEN
    send_item(KIND_NORM, 0, 0, 7, 7);
    send_item(KIND_MUL, 5, 0, 0, 3);
    send_item(KIND_NORM, 5, 0, 1, 1);
    send_item(KIND_DIV, 5, 3, 0, 2);
    // overflow on numerator and on denominator, and the negative limit that fits
    send_item(KIND_NORM, 32'h8000_0000, -1, 0, 0);
    send_item(KIND_MUL, 32'h0001_0000, 1, 32'h0001_0000, 1);
    send_item(KIND_NORM, 1, 32'h8000_0000, 0, 0);
    send_item(KIND_NORM, 32'h8000_0000, 1, 0, 0);
    drain_results();
  endtask

  task automatic test_random();
    int unsigned burst_left;
    logic [1:0] kind;
    logic signed [DATA_W-1:0] ln;
    logic signed [DATA_W-1:0] ld;
    logic signed [DATA_W-1:0] rn;
    logic signed [DATA_W-1:0] rd;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = 2'($urandom_range(0, 3));
      ln = pick_word();
      ld = pick_word();
      rn = pick_word();
      rd = pick_word();
      if (kind == KIND_CMP) begin
        if ($urandom_range(0, 1) == 1) rn = ln;
        if ($urandom_range(0, 1) == 1) rd = ld;
      end
      send_item(kind, ln, ld, rn, rd);
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0)
          idle_for($urandom_range(1, ($urandom_range(0, 1) == 1) ? 8 : 300));
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_kinds();
    test_special_cases();
    test_random();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_ratios.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
